[rtl/real_fft_radix2_twiddle_butterfly_assert.svh]
// Assertion macros used by the butterfly top level.
`ifndef REAL_FFT_RADIX2_TWIDDLE_BUTTERFLY_ASSERT_SVH
`define REAL_FFT_RADIX2_TWIDDLE_BUTTERFLY_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define RFT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check: antecedent in this cycle, consequent in the same cycle.
`define RFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication check: consequent in the cycle after the antecedent.
`define RFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rft_pkg.sv]
// Package: default widths and packing helper for the real FFT butterfly.
package rft_pkg;

  localparam int unsigned SAMPLE_BITS  = 32;
  localparam int unsigned TWIDDLE_BITS = 16;

  // Round a bit count up to whole bytes.
  function automatic int unsigned byte_bits(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

[rtl/rft_stage.sv]
// Pipeline register with valid/ready handshake.
module rft_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  output logic         s_ready_o,
  input  logic [W-1:0] s_data_i,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output logic [W-1:0] m_data_o
);

  logic         valid_q;
  logic         valid_d;
  logic [W-1:0] data_q;

  // take a new word whenever the held one is gone or leaves this cycle
  assign s_ready_o = !valid_q || m_ready_i;
  assign valid_d   = s_ready_o ? s_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= s_data_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

[rtl/rft_twiddle_mul.sv]
// Twiddle product t = w * x2 with rounding by 2^(TB-1).
module rft_twiddle_mul #(
  parameter int unsigned SB = rft_pkg::SAMPLE_BITS,
  parameter int unsigned TB = rft_pkg::TWIDDLE_BITS
) (
  input  logic signed [SB-1:0] x2_re_i,
  input  logic signed [SB-1:0] x2_im_i,
  input  logic signed [TB-1:0] tw_re_i,
  input  logic signed [TB-1:0] tw_im_i,
  output logic signed [SB+1:0] t_re_o,
  output logic signed [SB+1:0] t_im_o
);

  localparam int unsigned PW = SB + TB;

  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [PW:0]   s_re, s_im;
  logic signed [PW:0]   rnd;

  assign p_rr = PW'(tw_re_i) * PW'(x2_re_i);
  assign p_ii = PW'(tw_im_i) * PW'(x2_im_i);
  assign p_ir = PW'(tw_im_i) * PW'(x2_re_i);
  assign p_ri = PW'(tw_re_i) * PW'(x2_im_i);

  assign rnd = (PW+1)'(1) <<< (TB - 2);

  // exact sums, one rounding step each
  assign s_re = (PW+1)'(p_rr) - (PW+1)'(p_ii) + rnd;
  assign s_im = (PW+1)'(p_ir) + (PW+1)'(p_ri) + rnd;

  assign t_re_o = s_re[PW:TB-1];
  assign t_im_o = s_im[PW:TB-1];

endmodule

[rtl/rft_bfly_core.sv]
// Butterfly datapath: head / complex pair select, swap and saturation.
module rft_bfly_core #(
  parameter int unsigned SB = rft_pkg::SAMPLE_BITS,
  parameter int unsigned TB = rft_pkg::TWIDDLE_BITS
) (
  input  logic                 head_i,
  input  logic                 group_odd_i,
  input  logic signed [SB-1:0] x1_re_i,
  input  logic signed [SB-1:0] x1_im_i,
  input  logic signed [SB-1:0] x2_re_i,
  input  logic signed [SB-1:0] x2_im_i,
  input  logic signed [TB-1:0] tw_re_i,
  input  logic signed [TB-1:0] tw_im_i,
  output logic [SB-1:0]        lo_re_o,
  output logic [SB-1:0]        lo_im_o,
  output logic [SB-1:0]        hi_re_o,
  output logic [SB-1:0]        hi_im_o,
  output logic                 saturated_o
);

  localparam int unsigned RW = SB + 3;

  logic signed [SB+1:0] t_re, t_im;
  logic signed [RW-1:0] x1r, x1i, x2r, x2i, tr, ti;
  logic signed [RW-1:0] ar, ai, br, bi;
  logic signed [RW-1:0] r0, r1, r2, r3;
  logic [SB:0]          c0, c1, c2, c3;

  // returns {clipped, value}
  function automatic logic [SB:0] clip(input logic signed [RW-1:0] v);
    logic fits;
    fits = (&v[RW-1:SB-1]) || !(|v[RW-1:SB-1]);
    if (fits) begin
      return {1'b0, v[SB-1:0]};
    end else if (v[RW-1]) begin
      return {1'b1, 1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  rft_twiddle_mul #(
    .SB(SB),
    .TB(TB)
  ) u_mul (
    .x2_re_i(x2_re_i),
    .x2_im_i(x2_im_i),
    .tw_re_i(tw_re_i),
    .tw_im_i(tw_im_i),
    .t_re_o (t_re),
    .t_im_o (t_im)
  );

  assign x1r = RW'(x1_re_i);
  assign x1i = RW'(x1_im_i);
  assign x2r = RW'(x2_re_i);
  assign x2i = RW'(x2_im_i);
  assign tr  = RW'(t_re);
  assign ti  = RW'(t_im);

  assign ar = x1r + tr;
  assign ai = x1i + ti;
  assign br = x1r - tr;
  assign bi = ti - x1i;

  always_comb begin
    if (head_i) begin
      r0 = x1r + x2r;
      r1 = x1r - x2r;
      r2 = x1i;
      r3 = -x2i;
    end else if (group_odd_i) begin
      r0 = br;
      r1 = bi;
      r2 = ar;
      r3 = ai;
    end else begin
      r0 = ar;
      r1 = ai;
      r2 = br;
      r3 = bi;
    end
  end

  assign c0 = clip(r0);
  assign c1 = clip(r1);
  assign c2 = clip(r2);
  assign c3 = clip(r3);

  assign lo_re_o     = c0[SB-1:0];
  assign lo_im_o     = c1[SB-1:0];
  assign hi_re_o     = c2[SB-1:0];
  assign hi_im_o     = c3[SB-1:0];
  assign saturated_o = c0[SB] || c1[SB] || c2[SB] || c3[SB];

endmodule

[rtl/real_fft_radix2_twiddle_butterfly.sv]
// Top level: radix-2 real FFT butterfly with twiddle, stream in and out.
//
// Channel  Dir  tdata (low bit up)                          tuser (low bit up)
// s_axis   in   x1_re, x1_im, x2_re, x2_im, tw_re, tw_im    head, group_odd
// m_axis   out  lo_re, lo_im, hi_re, hi_im                  saturated
//
// One word per cycle while m_axis_tready is high. Each word goes through the
// input register, one multiply/add/saturate pass, then the result register.
// Reset (rst_ni low, async) empties both registers; payload is not reset.
// A stall on m_axis holds the result; the input register still takes one
// more word, after which s_axis_tready drops until the result leaves.
module real_fft_radix2_twiddle_butterfly #(
  parameter int unsigned SAMPLE_BITS  = rft_pkg::SAMPLE_BITS,
  parameter int unsigned TWIDDLE_BITS = rft_pkg::TWIDDLE_BITS
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    s_axis_tvalid,
  output logic                                                    s_axis_tready,
  // x1_re, x1_im, x2_re, x2_im, tw_re, tw_im, zero pad
  input  logic [rft_pkg::byte_bits(4*SAMPLE_BITS+2*TWIDDLE_BITS)-1:0] s_axis_tdata,
  // head, group_odd
  input  logic [1:0]                                              s_axis_tuser,
  output logic                                                    m_axis_tvalid,
  input  logic                                                    m_axis_tready,
  // lo_re, lo_im, hi_re, hi_im, zero pad
  output logic [rft_pkg::byte_bits(4*SAMPLE_BITS)-1:0]            m_axis_tdata,
  // saturated
  output logic                                                    m_axis_tuser
);

  import rft_pkg::*;

  `include "real_fft_radix2_twiddle_butterfly_assert.svh"

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned TB     = TWIDDLE_BITS;
  localparam int unsigned IN_USE = 4*SB + 2*TB;
  localparam int unsigned IN_W   = IN_USE + 2;
  localparam int unsigned OUT_W  = 4*SB + 1;
  localparam int unsigned OUT_DW = byte_bits(4*SB);

  logic [IN_W-1:0]  in_data;
  logic             s1_valid, s1_ready;
  logic [IN_W-1:0]  s1_data;
  logic [OUT_W-1:0] res_data;
  logic [OUT_W-1:0] out_data;

  // stage 1 word: {tdata fields, group_odd, head}
  assign in_data = {s_axis_tdata[IN_USE-1:0], s_axis_tuser};

  rft_stage #(
    .W(IN_W)
  ) u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i (in_data),
    .m_valid_o(s1_valid),
    .m_ready_i(s1_ready),
    .m_data_o (s1_data)
  );

  // field slices of the held input word
  logic                 s1_head, s1_odd;
  logic signed [SB-1:0] s1_x1_re, s1_x1_im, s1_x2_re, s1_x2_im;
  logic signed [TB-1:0] s1_tw_re, s1_tw_im;

  assign s1_head  = s1_data[0];
  assign s1_odd   = s1_data[1];
  assign s1_x1_re = s1_data[2+0*SB +: SB];
  assign s1_x1_im = s1_data[2+1*SB +: SB];
  assign s1_x2_re = s1_data[2+2*SB +: SB];
  assign s1_x2_im = s1_data[2+3*SB +: SB];
  assign s1_tw_re = s1_data[2+4*SB +: TB];
  assign s1_tw_im = s1_data[2+4*SB+TB +: TB];

  rft_bfly_core #(
    .SB(SB),
    .TB(TB)
  ) u_core (
    .head_i     (s1_head),
    .group_odd_i(s1_odd),
    .x1_re_i    (s1_x1_re),
    .x1_im_i    (s1_x1_im),
    .x2_re_i    (s1_x2_re),
    .x2_im_i    (s1_x2_im),
    .tw_re_i    (s1_tw_re),
    .tw_im_i    (s1_tw_im),
    .lo_re_o    (res_data[0*SB +: SB]),
    .lo_im_o    (res_data[1*SB +: SB]),
    .hi_re_o    (res_data[2*SB +: SB]),
    .hi_im_o    (res_data[3*SB +: SB]),
    .saturated_o(res_data[4*SB])
  );

  rft_stage #(
    .W(OUT_W)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s1_valid),
    .s_ready_o(s1_ready),
    .s_data_i (res_data),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (out_data)
  );

  assign m_axis_tdata = OUT_DW'(out_data[4*SB-1:0]);
  assign m_axis_tuser = out_data[4*SB];

  // ---- assertions ----
  logic [SB-1:0] sat_max, sat_min;
  assign sat_max = {1'b0, {(SB-1){1'b1}}};
  assign sat_min = {1'b1, {(SB-1){1'b0}}};

  // empty result register never blocks the input side
  `RFT_ASSERT_IMP(a_ready_when_out_empty, clk_i, rst_ni,
    !m_axis_tvalid, s_axis_tready, "input stalled with result register empty")

  // both registers full and output stalled: input must stall
  `RFT_ASSERT_IMP(a_stall_when_full, clk_i, rst_ni,
    s1_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready,
    "input accepted with pipeline full")

  // head word passes the second real straight to hi_re
  `RFT_ASSERT_NXT(a_head_hi_re, clk_i, rst_ni,
    s1_valid && s1_ready && s1_head,
    m_axis_tvalid && (out_data[2*SB +: SB] == $past(s1_x1_im)),
    "head item hi_re differs from second real")

  // a clip flag implies a value at one of the rails
  `RFT_ASSERT_IMP(a_sat_at_rail, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser,
    (out_data[0*SB +: SB] == sat_max) || (out_data[0*SB +: SB] == sat_min) ||
    (out_data[1*SB +: SB] == sat_max) || (out_data[1*SB +: SB] == sat_min) ||
    (out_data[2*SB +: SB] == sat_max) || (out_data[2*SB +: SB] == sat_min) ||
    (out_data[3*SB +: SB] == sat_max) || (out_data[3*SB +: SB] == sat_min),
    "saturated set but no output at a rail")

endmodule
